FILE: design/shift_add_fixed_point_logarithm_defines.svh
// Assertion macros shared by the logarithm block.
// They expect clk and rst_n in the scope where they are used.
`ifndef SHIFT_ADD_FIXED_POINT_LOGARITHM_DEFINES_SVH
`define SHIFT_ADD_FIXED_POINT_LOGARITHM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SAFL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SAFL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/safl_pkg.sv
`default_nettype none

package safl_pkg;

  // Width of the logarithm result.
  localparam int unsigned LOG_W = 21;
  localparam int unsigned ARG_W = 32;
  localparam int unsigned MODE_COUNT = 3;
  localparam int unsigned NORM_STEPS = 5;
  localparam int unsigned MUL_STEPS = 7;
  // Multiply steps done in the first of the two multiply stages.
  localparam int unsigned MUL_SPLIT = 3;

  typedef logic [LOG_W-1:0] log_t;
  typedef logic [ARG_W-1:0] arg_t;
  typedef logic [1:0] mode_t;

  // Mode codes.
  localparam mode_t MODE_LN_Q16 = 2'd0;
  localparam mode_t MODE_LN_Q7 = 2'd1;
  localparam mode_t MODE_LOG2_Q7 = 2'd2;

  localparam log_t START_VALUE [MODE_COUNT] = '{21'h0a65af, 21'h000851, 21'h000c00};

  localparam int unsigned NORM_SHIFT [NORM_STEPS] = '{16, 8, 4, 2, 1};

  localparam arg_t NORM_LIMIT [NORM_STEPS] = '{
    32'h0000_8000, 32'h0080_0000, 32'h0800_0000, 32'h2000_0000, 32'h4000_0000
  };

  localparam log_t NORM_SUB [MODE_COUNT][NORM_STEPS] = '{
    '{21'h0b1721, 21'h058b91, 21'h02c5c8, 21'h0162e4, 21'h00b172},
    '{21'h00058c, 21'h0002c6, 21'h000163, 21'h0000b1, 21'h000059},
    '{21'h000800, 21'h000400, 21'h000200, 21'h000100, 21'h000080}
  };

  localparam log_t MUL_SUB [MODE_COUNT][MUL_STEPS] = '{
    '{21'h0067cd, 21'h003920, 21'h001e27, 21'h000f85, 21'h0007e1, 21'h0003f8, 21'h0001fe},
    '{21'h000034, 21'h00001d, 21'h00000f, 21'h000008, 21'h000004, 21'h000002, 21'h000001},
    '{21'h00004b, 21'h000029, 21'h000016, 21'h00000b, 21'h000006, 21'h000003, 21'h000001}
  };

  localparam int unsigned CORR_SHIFT [MODE_COUNT] = '{15, 24, 24};

  localparam arg_t ONE_Q31 = 32'h8000_0000;

  // Data carried from stage to stage.
  typedef struct packed {
    arg_t  x;
    log_t  y;
    logic  err;
    mode_t mode;
  } stage_t;

endpackage

`default_nettype wire

FILE: design/shift_add_fixed_point_logarithm.sv
// Shift-and-add fixed-point logarithm.
// Input channel: in_valid, in_stall, in_argument (signed 32-bit, Q16 in
// mode 0, Q7 in modes 1 and 2). Result channel: out_valid, out_stall,
// out_log_value (signed 21-bit) and out_domain_error. A word moves on a
// channel at a rising edge where valid is high and stall is low.
// cfg_we with cfg_wdata sets the mode: 0 natural log Q16, 1 natural log
// Q7, 2 log base two Q7; code 3 behaves as mode 0. Change it only while
// no word is in flight.
// The datapath is four register stages: normalize, multiply steps one to
// three, multiply steps four to seven, then the linear correction into
// the output register. The accepting edge loads the first stage, and
// the word passes through the later stages to out_valid. One word is
// accepted every cycle while the receiver does not stall.
// A stall of a valid output word freezes all stages, so in_stall follows
// it in the same cycle; nothing is lost or repeated.
// A zero or negative argument gives out_domain_error high and a zero
// result. Reset empties the pipeline and sets the mode to 0.
`default_nettype none
`include "shift_add_fixed_point_logarithm_defines.svh"

module shift_add_fixed_point_logarithm
  import safl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic signed [31:0] in_argument,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic signed [20:0]     out_log_value,
  output logic                   out_domain_error
);

  mode_t  mode_r;
  logic   advance;
  logic   s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  stage_t s1_r, s2_r, s3_r;
  stage_t s1_nxt, s2_nxt, s3_nxt;
  log_t   out_log_r, out_log_nxt;
  logic   out_err_r;

  // Mode register; the reserved code maps to mode 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LN_Q16;
    end else if (cfg_we) begin
      mode_r <= (cfg_wdata == 2'd3) ? MODE_LN_Q16 : cfg_wdata;
    end
  end

  // The whole pipeline moves unless a finished word is held at the output.
  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;

  // Stage 1: normalize into [2^30, 2^31) with shifts of 16, 8, 4, 2, 1.
  always_comb begin
    s1_nxt.x    = arg_t'(in_argument);
    s1_nxt.mode = mode_r;
    s1_nxt.err  = (in_argument == '0) || in_argument[31];
    s1_nxt.y    = START_VALUE[mode_r];
    for (int i = 0; i < NORM_STEPS; i++) begin
      if (s1_nxt.x < NORM_LIMIT[i]) begin
        s1_nxt.x = s1_nxt.x << NORM_SHIFT[i];
        s1_nxt.y = s1_nxt.y - NORM_SUB[s1_nxt.mode][i];
      end
    end
  end

  // Stage 2: the first multiply-by-(1 + 2^-k) steps.
  always_comb begin
    arg_t t;
    s2_nxt = s1_r;
    for (int i = 0; i < MUL_SPLIT; i++) begin
      t = s2_nxt.x + (s2_nxt.x >> (i + 1));
      if (!t[ARG_W-1]) begin
        s2_nxt.x = t;
        s2_nxt.y = s2_nxt.y - MUL_SUB[s2_nxt.mode][i];
      end
    end
  end

  // Stage 3: the remaining multiply steps.
  always_comb begin
    arg_t t;
    s3_nxt = s2_r;
    for (int i = MUL_SPLIT; i < MUL_STEPS; i++) begin
      t = s3_nxt.x + (s3_nxt.x >> (i + 1));
      if (!t[ARG_W-1]) begin
        s3_nxt.x = t;
        s3_nxt.y = s3_nxt.y - MUL_SUB[s3_nxt.mode][i];
      end
    end
  end

  // Stage 4: linear correction, and a zero result on a domain error.
  always_comb begin
    arg_t d;
    arg_t ds;
    d  = ONE_Q31 - s3_r.x;
    ds = d >> CORR_SHIFT[s3_r.mode];
    out_log_nxt = s3_r.err ? '0 : (s3_r.y - ds[LOG_W-1:0]);
  end

  // Valid bits travel with the data and all stages share one enable.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r      <= s1_nxt;
      s2_r      <= s2_nxt;
      s3_r      <= s3_nxt;
      out_log_r <= out_log_nxt;
      out_err_r <= s3_r.err;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_log_value    = signed'(out_log_r);
  assign out_domain_error = out_err_r;

  // Checks on the pipeline control and the error path.
  `SAFL_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, s1_valid_r, "accepted word lost")
  `SAFL_ASSERT_NEXT(a_last_reaches_out, s3_valid_r && !in_stall, out_valid, "word dropped at output")
  `SAFL_ASSERT_SAME(a_error_zero, out_valid && out_domain_error, out_log_value == '0,
                    "domain error with nonzero result")

endmodule

`default_nettype wire
